// ----- design/keyed_entry_table_with_aging_unit_macros.svh -----
// Assertion macros shared by the keyed entry table RTL.
`ifndef KEYED_ENTRY_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define KEYED_ENTRY_TABLE_WITH_AGING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a same-cycle implication, quiet while reset is held.
`define KETA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle leads to a consequence in the next.
`define KETA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KETA_ASSERT(lbl, clk, rst_n, prop, msg)
`define KETA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/keta_pkg.sv -----
// Shared types and constants for the keyed entry table with aging.
`timescale 1ns / 1ps

package keta_pkg;

    localparam int KEY_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 32;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd3;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_JOINT  = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_ALLOCATED = 3'd1,
        STS_DROPPED   = 3'd2,
        STS_HIT       = 3'd3,
        STS_MISS      = 3'd4,
        STS_TICK_DONE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_MATCH  = 3'd1,
        S_FIND   = 3'd2,
        S_ACCESS = 3'd3,
        S_SWEEP  = 3'd4,
        S_REPLY  = 3'd5
    } t_state;

    // Commands from the sequencer to the key store.
    typedef struct packed {
        logic search;
        logic alloc;
        logic expire;
    } t_cam_ctl;

    // Search result of the key store.
    typedef struct packed {
        logic hit;
        logic free_any;
    } t_cam_res;

endpackage

// ----- design/keyed_entry_table_with_aging_unit.sv -----
// Top level of the keyed entry table with entry aging.
`timescale 1ns / 1ps
`include "keyed_entry_table_with_aging_unit_macros.svh"
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item: update,
//   joint update, lookup or time tick. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result item per request, in order.
//   The config channel (i_cfg_valid / o_cfg_ready) writes timeout_ticks; it is
//   always ready. Write it only while the block is idle; the block does not enforce it.
// Sequencing:
//   Update, joint update and lookup pass a registered key match, a priority
//   encode, a memory access and a reply, in that order.
//   A tick sweeps the stamp memory one entry per cycle through its single read
//   port and then moves to its reply.
//   A new item is accepted in the cycle its predecessor's result is loaded, so
//   no new request or tick is taken before the last one has reached its reply.
// Reset:
//   Synchronous, active low. Clears all valid bits, time to zero and timeout
//   to 3. Key, stamp, flag, payload and joint stores are not cleared.
// Backpressure:
//   The result waits in the output register while i_out_stall is high; the
//   next item is still accepted and processed up to its reply stage.

module keyed_entry_table_with_aging_unit import keta_pkg::*; #(
    parameter int ENTRIES       = 16,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int JOINT_WIDTH   = 64,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_req_type,
    input  logic [KEY_W-1:0]         i_net_id,
    input  logic                     i_has_payload,
    input  logic                     i_in_game,
    input  logic [PAYLOAD_WIDTH-1:0] i_payload,
    input  logic [JOINT_WIDTH-1:0]   i_joint_data,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic [SLOT_W-1:0]        o_slot,
    output logic                     o_out_in_game,
    output logic [PAYLOAD_WIDTH-1:0] o_out_payload,
    output logic [JOINT_WIDTH-1:0]   o_out_joint,
    output logic [COUNT_W-1:0]       o_expired_count,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SCAN_W = $clog2(ENTRIES + 1);
    localparam int META_W = TIME_WIDTH + 1;
    localparam int CMP_W  = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    // sequencer
    t_state r_state, n_state;
    logic   w_accept;
    logic   w_out_free;
    logic   w_out_load;

    // captured request
    t_req                     r_req;
    logic [KEY_W-1:0]         r_net_id;
    logic                     r_has_payload;
    logic                     r_in_game;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [JOINT_WIDTH-1:0]   r_joint_data;

    // global state
    logic [TIME_WIDTH-1:0] r_time;
    logic [CFG_W-1:0]      r_timeout;

    // resolved entry
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;

    // tick sweep
    logic [SCAN_W-1:0]  r_scan;
    logic               r_chk_valid;
    logic [IDX_W-1:0]   r_chk_idx;
    logic [SCAN_W-1:0]  r_count;
    logic               w_issue;
    logic               w_expire;
    logic [TIME_WIDTH-1:0] w_age;

    // key store
    t_cam_ctl           w_cam_ctl;
    t_cam_res           w_cam_res;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [IDX_W-1:0]   w_free_idx;
    logic [ENTRIES-1:0] w_valid_vec;

    // memories
    logic                     w_meta_we;
    logic                     w_meta_re;
    logic [IDX_W-1:0]         w_meta_raddr;
    logic [META_W-1:0]        w_meta_rdata;
    logic                     w_pl_we;
    logic                     w_jt_we;
    logic                     w_data_re;
    logic [PAYLOAD_WIDTH-1:0] w_pl_rdata;
    logic [JOINT_WIDTH-1:0]   w_jt_rdata;

    // output register
    logic                     r_out_valid;
    t_status                  r_o_status;
    logic [SLOT_W-1:0]        r_o_slot;
    logic                     r_o_in_game;
    logic [PAYLOAD_WIDTH-1:0] r_o_payload;
    logic [JOINT_WIDTH-1:0]   r_o_joint;
    logic [COUNT_W-1:0]       r_o_expired;

    // ---------------------------------------------------------------- handshake
    // Take a new item when idle, or in the reply cycle that frees the pipeline.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_REPLY) && w_out_free));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_req'(i_req_type) == REQ_TICK) ? S_SWEEP : S_MATCH;
                end
            end
            S_MATCH:  n_state = S_FIND;
            S_FIND:   n_state = S_ACCESS;
            S_ACCESS: n_state = S_REPLY;
            S_SWEEP: begin
                // leave once the last stamp read has been checked
                if ((r_scan == SCAN_W'(ENTRIES)) && r_chk_valid) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (w_accept) begin
                        n_state = (t_req'(i_req_type) == REQ_TICK) ? S_SWEEP : S_MATCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req         <= t_req'(i_req_type);
            r_net_id      <= i_net_id;
            r_has_payload <= i_has_payload;
            r_in_game     <= i_in_game;
            r_payload     <= i_payload;
            r_joint_data  <= i_joint_data;
        end
    end

    // Advance time on tick accept, so the sweep sees the new time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (w_accept && (t_req'(i_req_type) == REQ_TICK)) begin
                r_time <= r_time + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------- key store
    always_comb begin
        w_cam_ctl        = '0;
        w_cam_ctl.search = (r_state == S_MATCH);
        w_cam_ctl.alloc  = (r_state == S_ACCESS) && r_found && (r_status == STS_ALLOCATED);
        w_cam_ctl.expire = w_expire;
    end

    keta_key_cam #(
        .ENTRIES (ENTRIES)
    ) u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_cam_ctl),
        .i_key        (r_net_id),
        .i_alloc_idx  (r_idx),
        .i_expire_idx (r_chk_idx),
        .o_res        (w_cam_res),
        .o_hit_idx    (w_hit_idx),
        .o_free_idx   (w_free_idx),
        .o_valid      (w_valid_vec)
    );

    // ---------------------------------------------------------------- resolve entry
    // Existing key first, else the lowest free entry for an update.
    always_comb begin
        n_status = STS_MISS;
        n_idx    = '0;
        n_found  = 1'b0;
        unique case (r_req)
            REQ_UPDATE: begin
                if (w_cam_res.hit) begin
                    n_status = STS_UPDATED;
                    n_idx    = w_hit_idx;
                    n_found  = 1'b1;
                end else if (w_cam_res.free_any) begin
                    n_status = STS_ALLOCATED;
                    n_idx    = w_free_idx;
                    n_found  = 1'b1;
                end else begin
                    n_status = STS_DROPPED;
                end
            end
            REQ_JOINT: begin
                if (w_cam_res.hit) begin
                    n_status = STS_UPDATED;
                    n_idx    = w_hit_idx;
                    n_found  = 1'b1;
                end
            end
            REQ_LOOKUP: begin
                if (w_cam_res.hit) begin
                    n_status = STS_HIT;
                    n_idx    = w_hit_idx;
                    n_found  = 1'b1;
                end
            end
            REQ_TICK: n_status = STS_TICK_DONE;
            default:  n_status = STS_MISS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_status <= STS_MISS;
        end else if (w_accept) begin
            r_found  <= 1'b0;
            r_status <= STS_TICK_DONE;
        end else if (r_state == S_FIND) begin
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND) begin
            r_idx <= n_idx;
        end
    end

    // ---------------------------------------------------------------- memories
    // Stamp and flag share one word; the sweep and the access stage share its read port.
    assign w_issue      = (r_state == S_SWEEP) && (r_scan != SCAN_W'(ENTRIES));
    assign w_meta_we    = (r_state == S_ACCESS) && r_found && (r_req == REQ_UPDATE);
    assign w_meta_re    = (r_state == S_ACCESS) || w_issue;
    assign w_meta_raddr = (r_state == S_SWEEP) ? r_scan[IDX_W-1:0] : r_idx;
    assign w_pl_we      = w_meta_we && r_has_payload;
    assign w_jt_we      = (r_state == S_ACCESS) && r_found && (r_req == REQ_JOINT);
    assign w_data_re    = (r_state == S_ACCESS);

    keta_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (META_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (r_idx),
        .i_wdata ({r_in_game, r_time}),
        .i_re    (w_meta_re),
        .i_raddr (w_meta_raddr),
        .o_rdata (w_meta_rdata)
    );

    keta_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_pl_we),
        .i_waddr (r_idx),
        .i_wdata (r_payload),
        .i_re    (w_data_re),
        .i_raddr (r_idx),
        .o_rdata (w_pl_rdata)
    );

    keta_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (JOINT_WIDTH)
    ) u_joint_ram (
        .i_clk   (i_clk),
        .i_we    (w_jt_we),
        .i_waddr (r_idx),
        .i_wdata (r_joint_data),
        .i_re    (w_data_re),
        .i_raddr (r_idx),
        .o_rdata (w_jt_rdata)
    );

    // ---------------------------------------------------------------- tick sweep
    // One stamp read per cycle; check the entry read in the previous cycle.
    assign w_age    = r_time - w_meta_rdata[TIME_WIDTH-1:0];
    assign w_expire = (r_state == S_SWEEP) && r_chk_valid && w_valid_vec[r_chk_idx]
                      && (CMP_W'(w_age) > CMP_W'(r_timeout));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_chk_valid <= 1'b0;
            r_count     <= '0;
        end else if (w_accept) begin
            r_scan      <= '0;
            r_chk_valid <= 1'b0;
            r_count     <= '0;
        end else if (r_state == S_SWEEP) begin
            if (w_issue) begin
                r_scan <= r_scan + 1'b1;
            end
            r_chk_valid <= w_issue;
            if (w_expire) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_chk_idx <= r_scan[IDX_W-1:0];
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_status  <= (r_req == REQ_TICK) ? STS_TICK_DONE : r_status;
            r_o_slot    <= r_found ? SLOT_W'(r_idx) : '0;
            // an update reports the flag it just wrote; others report the stored one
            r_o_in_game <= r_found && ((r_req == REQ_UPDATE) ? r_in_game
                                                            : w_meta_rdata[TIME_WIDTH]);
            r_o_payload <= (r_found && (r_req == REQ_LOOKUP)) ? w_pl_rdata : '0;
            r_o_joint   <= (r_found && (r_req == REQ_LOOKUP)) ? w_jt_rdata : '0;
            r_o_expired <= (r_req == REQ_TICK) ? COUNT_W'(r_count) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_out_in_game   = r_o_in_game;
    assign o_out_payload   = r_o_payload;
    assign o_out_joint     = r_o_joint;
    assign o_expired_count = r_o_expired;

    `KETA_ASSERT(a_sweep_drain, i_clk, i_rst_n, (((r_state == S_SWEEP) && (r_scan == SCAN_W'(ENTRIES))) |-> r_chk_valid), "sweep ended without last check")
    `KETA_ASSERT(a_found_live, i_clk, i_rst_n, (((r_state == S_ACCESS) && r_found && (r_status != STS_ALLOCATED)) |-> w_valid_vec[r_idx]), "resolved entry not valid")
    `KETA_ASSERT(a_miss_blank, i_clk, i_rst_n, ((o_out_valid && ((o_status == STS_MISS) || (o_status == STS_DROPPED) || (o_status == STS_TICK_DONE))) |-> ((o_slot == '0) && !o_out_in_game && (o_out_payload == '0))), "miss result carries data")
    `KETA_ASSERT(a_count_tick, i_clk, i_rst_n, ((o_out_valid && (o_status != STS_TICK_DONE)) |-> (o_expired_count == '0)), "expired count outside tick")

endmodule

// ----- design/keta_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module keta_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/keta_key_cam.sv -----
// Key store with valid bits, parallel key match and lowest-index encoders.
`timescale 1ns / 1ps
`include "keyed_entry_table_with_aging_unit_macros.svh"

module keta_key_cam import keta_pkg::*; #(
    parameter int ENTRIES = 16,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cam_ctl           i_ctl,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [IDX_W-1:0]   i_alloc_idx,
    input  logic [IDX_W-1:0]   i_expire_idx,
    output t_cam_res           o_res,
    output logic [IDX_W-1:0]   o_hit_idx,
    output logic [IDX_W-1:0]   o_free_idx,
    output logic [ENTRIES-1:0] o_valid
);

    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [ENTRIES-1:0] r_hit_vec;
    logic [ENTRIES-1:0] n_hit_vec;
    logic [ENTRIES-1:0] r_free_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.alloc) begin
                r_valid[i_alloc_idx] <= 1'b1;
            end
            if (i_ctl.expire) begin
                r_valid[i_expire_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_key[i_alloc_idx] <= i_key;
        end
    end

    // Compare every stored key in parallel; register the match and free vectors.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_hit_vec[i] = r_valid[i] && (r_key[i] == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_vec  <= '0;
            r_free_vec <= '0;
        end else if (i_ctl.search) begin
            r_hit_vec  <= n_hit_vec;
            r_free_vec <= ~r_valid;
        end
    end

    // Lowest index wins in both encoders.
    always_comb begin
        o_res      = '0;
        o_hit_idx  = '0;
        o_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                o_res.hit = 1'b1;
                o_hit_idx = IDX_W'(i);
            end
            if (r_free_vec[i]) begin
                o_res.free_any = 1'b1;
                o_free_idx     = IDX_W'(i);
            end
        end
    end

    assign o_valid = r_valid;

    `KETA_ASSERT(a_key_unique, i_clk, i_rst_n, ($onehot0(r_hit_vec)), "key held by two entries")
    `KETA_ASSERT(a_alloc_free, i_clk, i_rst_n, (i_ctl.alloc |-> !r_valid[i_alloc_idx]), "alloc hit a live entry")
    `KETA_ASSERT_NEXT(a_alloc_sets, i_clk, i_rst_n, i_ctl.alloc, r_valid[$past(i_alloc_idx)], "alloc left entry invalid")

endmodule

// ----- bench/tb_keyed_entry_table_with_aging_unit.sv -----
// Self-checking bench for the keyed entry table with aging: directed items, then random phases.
`timescale 1ns / 1ps

module tb_keyed_entry_table_with_aging_unit;
    import keta_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int DATA_W      = 64;
    localparam int STAMP_W     = 32;
    localparam int PHASE_ITEMS = 240;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int SETTLE      = 40;    // idle clocks after the last reply before the next phase
    localparam int QUIET_LIMIT = 4000;  // cycles with no handshake before the run is abandoned
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_req              kind;
        logic [KEY_W-1:0]  id;
        logic              has_pl;
        logic              game;
        logic [DATA_W-1:0] pl;
        logic [DATA_W-1:0] jd;
    } t_request;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic               game;
        logic [DATA_W-1:0]  pl;
        logic [DATA_W-1:0]  jt;
        logic [COUNT_W-1:0] expired;
    } t_reply;

    // Shadow copy of the table; predicts one reply per accepted request.
    class table_tracker;
        bit                 live [NUM_ENTRIES];
        logic [KEY_W-1:0]   key_of [NUM_ENTRIES];
        logic [STAMP_W-1:0] stamp_of [NUM_ENTRIES];
        logic               game_of [NUM_ENTRIES];
        logic [DATA_W-1:0]  pl_of [NUM_ENTRIES];
        logic [DATA_W-1:0]  jt_of [NUM_ENTRIES];
        bit                 pl_known [NUM_ENTRIES];
        bit                 jt_known [NUM_ENTRIES];
        logic [STAMP_W-1:0] now;
        logic [CFG_W-1:0]   timeout;
        t_reply             expected_replies [$];
        int                 failures;

        function new();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                live[i]     = 1'b0;
                key_of[i]   = '0;
                stamp_of[i] = '0;
                game_of[i]  = 1'b0;
                pl_of[i]    = '0;
                jt_of[i]    = '0;
                pl_known[i] = 1'b0;
                jt_known[i] = 1'b0;
            end
            now      = '0;
            timeout  = TIMEOUT_RESET;
            failures = 0;
        endfunction

        function void set_timeout(logic [CFG_W-1:0] value);
            timeout = value;
        endfunction

        function int find_key(logic [KEY_W-1:0] id);
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (live[i] && key_of[i] == id) return i;
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (!live[i]) return i;
            return -1;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_request(t_request r);
            t_reply           e;
            int               idx;
            int               freed;
            logic [STAMP_W-1:0] age;
            e.status  = STS_UPDATED;
            e.slot    = '0;
            e.game    = 1'b0;
            e.pl      = '0;
            e.jt      = '0;
            e.expired = '0;
            case (r.kind)
                REQ_UPDATE: begin
                    idx = find_key(r.id);
                    if (idx < 0) begin
                        idx = find_free();
                        if (idx >= 0) begin
                            e.status    = STS_ALLOCATED;
                            live[idx]   = 1'b1;
                            key_of[idx] = r.id;
                        end else begin
                            e.status = STS_DROPPED;
                        end
                    end
                    if (idx >= 0) begin
                        stamp_of[idx] = now;
                        game_of[idx]  = r.game;
                        // a missing payload leaves the old word in place, even on allocation
                        if (r.has_pl) begin
                            pl_of[idx]    = r.pl;
                            pl_known[idx] = 1'b1;
                        end
                        e.slot = SLOT_W'(idx);
                        e.game = r.game;
                    end
                end
                REQ_JOINT: begin
                    idx = find_key(r.id);
                    if (idx >= 0) begin
                        jt_of[idx]    = r.jd;
                        jt_known[idx] = 1'b1;
                        e.slot        = SLOT_W'(idx);
                        e.game        = game_of[idx];
                    end else begin
                        e.status = STS_MISS;
                    end
                end
                REQ_LOOKUP: begin
                    idx = find_key(r.id);
                    if (idx >= 0) begin
                        e.status = STS_HIT;
                        e.slot   = SLOT_W'(idx);
                        e.game   = game_of[idx];
                        e.pl     = pl_of[idx];
                        e.jt     = jt_of[idx];
                    end else begin
                        e.status = STS_MISS;
                    end
                end
                default: begin
                    now   = now + 1'b1;
                    freed = 0;
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        age = now - stamp_of[i];
                        if (live[i] && age > timeout) begin
                            live[i] = 1'b0;
                            freed++;
                        end
                    end
                    e.status  = STS_TICK_DONE;
                    e.expired = COUNT_W'(freed);
                end
            endcase
            expected_replies.push_back(e);
        endfunction

        function void check_reply(t_reply got);
            t_reply e;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected reply: status %0d slot %0d", got.status, got.slot);
                return;
            end
            e = expected_replies.pop_front();
            if (got.status != e.status || got.slot != e.slot || got.game != e.game ||
                got.pl != e.pl || got.jt != e.jt || got.expired != e.expired) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("reply mismatch at %0t", $realtime);
                    $display("  expected status %0d slot %0d game %0d pl %h jt %h expired %0d",
                             e.status, e.slot, e.game, e.pl, e.jt, e.expired);
                    $display("  actual   status %0d slot %0d game %0d pl %h jt %h expired %0d",
                             got.status, got.slot, got.game, got.pl, got.jt, got.expired);
                end
            end
        endfunction

        function void close_out();
            if (expected_replies.size() != 0) begin
                $display("%0d replies never arrived", expected_replies.size());
                failures += expected_replies.size();
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_req_type = REQ_UPDATE;
    logic [KEY_W-1:0]     i_net_id = '0;
    logic                 i_has_payload = 1'b0;
    logic                 i_in_game = 1'b0;
    logic [DATA_W-1:0]    i_payload = '0;
    logic [DATA_W-1:0]    i_joint_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_out_in_game;
    logic [DATA_W-1:0]    o_out_payload;
    logic [DATA_W-1:0]    o_out_joint;
    logic [COUNT_W-1:0]   o_expired_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    table_tracker sb = new();

    // Idling control shared by the driver and the receiver.
    logic calm = 1'b0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet = 0;

    logic [KEY_W-1:0] key_pool [20];

    keyed_entry_table_with_aging_unit #(
        .ENTRIES      (NUM_ENTRIES),
        .PAYLOAD_WIDTH(DATA_W),
        .JOINT_WIDTH  (DATA_W),
        .TIME_WIDTH   (STAMP_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_net_id       (i_net_id),
        .i_has_payload  (i_has_payload),
        .i_in_game      (i_in_game),
        .i_payload      (i_payload),
        .i_joint_data   (i_joint_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_out_in_game  (o_out_in_game),
        .o_out_payload  (o_out_payload),
        .o_out_joint    (o_out_joint),
        .o_expired_count(o_expired_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: random stalls, none while calm, and a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 16);
        end
    end

    // Check every reply taken from the block.
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status  = t_status'(o_status);
            got.slot    = o_slot;
            got.game    = o_out_in_game;
            got.pl      = o_out_payload;
            got.jt      = o_out_joint;
            got.expired = o_expired_count;
            sb.check_reply(got);
        end
    end

    // Abandon the run when no channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until accepted, then predict its reply.
    task automatic send_request(t_request r);
        i_in_valid    <= 1'b1;
        i_req_type    <= r.kind;
        i_net_id      <= r.id;
        i_has_payload <= r.has_pl;
        i_in_game     <= r.game;
        i_payload     <= r.pl;
        i_joint_data  <= r.jd;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic send_fields(t_req kind, logic [KEY_W-1:0] id, logic has_pl, logic game,
                               logic [DATA_W-1:0] pl, logic [DATA_W-1:0] jd);
        t_request r;
        r.kind   = kind;
        r.id     = id;
        r.has_pl = has_pl;
        r.game   = game;
        r.pl     = pl;
        r.jd     = jd;
        send_request(r);
    endtask

    // Stop offering, let every reply come back, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_timeout(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly pool keys so entries get hit, refreshed, aged and dropped.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       idx;
        pick     = $urandom_range(99);
        r.kind   = (pick < 40) ? REQ_UPDATE : (pick < 60) ? REQ_JOINT :
                   (pick < 85) ? REQ_LOOKUP : REQ_TICK;
        r.id     = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(19)];
        r.has_pl = ($urandom_range(9) < 7);
        r.game   = 1'($urandom_range(1));
        r.pl     = random_word();
        r.jd     = random_word();
        // never read back a word the table has not been given yet
        if (r.kind == REQ_LOOKUP) begin
            idx = sb.find_key(r.id);
            if (idx >= 0 && !sb.pl_known[idx]) begin
                r.kind   = REQ_UPDATE;
                r.has_pl = 1'b1;
            end else if (idx >= 0 && !sb.jt_known[idx]) begin
                r.kind = REQ_JOINT;
            end
        end
        return r;
    endfunction

    initial begin
        logic [CFG_W-1:0] timeouts [6];
        t_request         r;

        for (int i = 0; i < 20; i++) key_pool[i] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        timeouts = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd5, CFG_W'($urandom_range(1, 8)), 32'd3};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, timeout at its reset value.
        send_fields(REQ_LOOKUP, 16'h0000, 1'b0, 1'b0, '0, '0);      // empty table miss
        send_fields(REQ_JOINT,  16'h0000, 1'b0, 1'b0, '0, '1);      // joint update miss
        send_fields(REQ_UPDATE, 16'h0000, 1'b1, 1'b1, '1, '0);      // allocate slot 0
        send_fields(REQ_JOINT,  16'h0000, 1'b0, 1'b0, '0, '1);      // joint update hit
        send_fields(REQ_UPDATE, 16'h0000, 1'b0, 1'b0, '0, '0);      // refresh, payload kept
        send_fields(REQ_LOOKUP, 16'h0000, 1'b0, 1'b0, '0, '0);
        send_fields(REQ_UPDATE, 16'hFFFF, 1'b1, 1'b0, '0, '1);
        for (int k = 1; k <= 14; k++)
            send_fields(REQ_UPDATE, KEY_W'(k), 1'b1, k[0], {$urandom, $urandom}, '0);
        send_fields(REQ_UPDATE, 16'h8000, 1'b1, 1'b1, '1, '1);      // table full, dropped
        // age 4 exceeds 3 on the fourth tick: every entry expires at once
        repeat (4) send_fields(REQ_TICK, 16'h0000, 1'b0, 1'b0, '0, '0);
        // reallocate slot 0 without payload: old payload and joint words remain
        send_fields(REQ_UPDATE, 16'h5A5A, 1'b0, 1'b1, '0, '0);
        send_fields(REQ_LOOKUP, 16'h5A5A, 1'b0, 1'b0, '0, '0);

        // Random phases, one timeout setting each, written while idle.
        for (int p = 0; p < 6; p++) begin
            drain();
            write_timeout(timeouts[p]);
            calm <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 60) hold_requests <= hold_requests + 1;
                if (p == 4 && n == 120) drain();
                if (!calm && $urandom_range(99) < 16) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
                r = random_request();
                send_request(r);
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
